// ===== design/iqts_pkg.sv =====
// Shared constants, codes and types of the I/Q time-shift ring buffer.
package iqts_pkg;

    // Fixed field widths.
    localparam int CAP_W   = 13;
    localparam int LEN_W   = 7;
    localparam int DELAY_W = 12;
    localparam int OP_W    = 2;

    // Defaults of the top-level parameters.
    localparam int MAX_FRAMES_DEF  = 4096;
    localparam int MAX_READ_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register index of the capacity register (byte address 4 * index).
    localparam logic REG_CAPACITY = 1'b0;

    // Item operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    // Configuration handed from the register block to the core.
    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic             hist_clear;
    } iqts_cfg_t;

endpackage

// ===== design/iqts_core.sv =====
// Ring store, window address sequencer and output queue of the I/Q time-shift buffer.
module iqts_core
    import iqts_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int MAX_READ    = MAX_READ_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  iqts_cfg_t              cfg,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [OP_W-1:0]        s_opcode,
    input  logic [SAMPLE_BITS-1:0] s_sample_i,
    input  logic [SAMPLE_BITS-1:0] s_sample_q,
    input  logic [LEN_W-1:0]       s_read_length,
    input  logic [DELAY_W-1:0]     s_delay,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_BITS-1:0] m_out_i,
    output logic [SAMPLE_BITS-1:0] m_out_q,
    output logic [LEN_W-1:0]       m_returned_count,
    output logic                   m_empty_res,
    output logic                   m_last
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int XW = (AW > CAP_W) ? AW : CAP_W;
    localparam int SB = SAMPLE_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_CLAMP, ST_ADDR, ST_STREAM} state_t;

    typedef struct packed {
        logic [SB-1:0]    i;
        logic [SB-1:0]    q;
        logic [LEN_W-1:0] count;
        logic             empty;
        logic             last;
    } entry_t;

    // Frame store: Q in the upper half, I in the lower half.
    logic [2*SB-1:0] mem [MAX_FRAMES];
    logic [2*SB-1:0] rd_data_reg;

    state_t           state_reg, state_next;
    logic [CAP_W-1:0] head_reg, head_next;
    logic [CAP_W-1:0] fill_reg, fill_next;
    logic [LEN_W-1:0] wanted_reg, wanted_next;
    logic [DELAY_W-1:0] dly_reg, dly_next;
    logic             empty_reg, empty_next;
    logic [CAP_W-1:0] back_reg, back_next;
    logic [CAP_W-1:0] ptr_reg, ptr_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic             infl_reg, infl_next;
    logic             infl_last_reg, infl_last_next;
    logic             infl_empty_reg, infl_empty_next;
    logic [LEN_W-1:0] infl_cnt_reg, infl_cnt_next;
    logic [1:0]       q_cnt_reg, q_cnt_next;
    entry_t           ent0_reg, ent0_next;
    entry_t           ent1_reg, ent1_next;

    logic             accept;
    logic             pop;
    logic             credit;
    logic [1:0]       occ;
    logic             wr_en;
    logic             rd_en;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] wanted_c;
    logic [CAP_W-1:0] deepest;
    logic [CAP_W-1:0] dly_c;
    logic [CAP_W:0]   start_sum;
    logic [CAP_W-1:0] head_inc;
    logic [CAP_W-1:0] ptr_inc;
    logic [XW-1:0]    wr_addr_x;
    logic [XW-1:0]    rd_addr_x;
    entry_t           new_ent;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = (q_cnt_reg != 2'd0);
    assign pop       = m_tvalid && m_tready;
    assign wr_addr_x = XW'(head_reg);
    assign rd_addr_x = XW'(ptr_reg);

    // A read is issued only when the queue has room for its data.
    assign occ    = q_cnt_reg + {1'b0, infl_reg};
    assign credit = (occ < 2'd2) || ((occ == 2'd2) && pop);

    // Request trimming and pointer increments.
    assign len_sat  = (s_read_length > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : s_read_length;
    assign wanted_c = (CAP_W'(len_sat) < fill_reg) ? len_sat : fill_reg[LEN_W-1:0];
    assign deepest  = fill_reg - CAP_W'(wanted_reg);
    assign dly_c    = (CAP_W'(dly_reg) > deepest) ? deepest : CAP_W'(dly_reg);
    assign start_sum = (CAP_W+1)'(head_reg) + (CAP_W+1)'(cfg.capacity)
                     - (CAP_W+1)'(back_reg);
    assign head_inc = (head_reg + 1'b1 == cfg.capacity) ? '0 : head_reg + 1'b1;
    assign ptr_inc  = (ptr_reg + 1'b1 == cfg.capacity) ? '0 : ptr_reg + 1'b1;

    // Sequencer: write, clear, or trim the window, find its start and issue reads.
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        wanted_next     = wanted_reg;
        dly_next        = dly_reg;
        empty_next      = empty_reg;
        back_next       = back_reg;
        ptr_next        = ptr_reg;
        rem_next        = rem_reg;
        infl_next       = 1'b0;
        infl_last_next  = infl_last_reg;
        infl_empty_next = infl_empty_reg;
        infl_cnt_next   = infl_cnt_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (opcode_t'(s_opcode))
                        OP_WRITE: begin
                            if (cfg.capacity != '0) begin
                                wr_en     = 1'b1;
                                head_next = head_inc;
                                if (fill_reg < cfg.capacity) begin
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            wanted_next = wanted_c;
                            dly_next    = s_delay;
                            empty_next  = (cfg.capacity == '0) || (wanted_c == '0);
                            state_next  = ST_CLAMP;
                        end
                        OP_CLEAR: begin
                            head_next = '0;
                            fill_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLAMP: begin
                back_next  = CAP_W'(wanted_reg) + dly_c;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                if (start_sum >= (CAP_W+1)'(cfg.capacity)) begin
                    ptr_next = CAP_W'(start_sum - (CAP_W+1)'(cfg.capacity));
                end else begin
                    ptr_next = CAP_W'(start_sum);
                end
                rem_next   = empty_reg ? LEN_W'(1) : wanted_reg;
                state_next = ST_STREAM;
            end
            ST_STREAM: begin
                if (credit) begin
                    rd_en           = !empty_reg;
                    infl_next       = 1'b1;
                    infl_last_next  = (rem_reg == LEN_W'(1));
                    infl_empty_next = empty_reg;
                    infl_cnt_next   = empty_reg ? '0 : wanted_reg;
                    ptr_next        = ptr_inc;
                    rem_next        = rem_reg - 1'b1;
                    if (rem_reg == LEN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg.hist_clear) begin
            head_next = '0;
            fill_next = '0;
        end
    end

    // Data arriving from the store, or the fixed empty result.
    always_comb begin
        new_ent.i     = infl_empty_reg ? '0 : rd_data_reg[SB-1:0];
        new_ent.q     = infl_empty_reg ? '0 : rd_data_reg[2*SB-1:SB];
        new_ent.count = infl_cnt_reg;
        new_ent.empty = infl_empty_reg;
        new_ent.last  = infl_last_reg;
    end

    // Two-entry output queue; entry zero faces the result channel.
    always_comb begin
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        q_cnt_next = q_cnt_reg;
        if (pop && infl_reg) begin
            if (q_cnt_reg == 2'd2) begin
                ent0_next = ent1_reg;
                ent1_next = new_ent;
            end else begin
                ent0_next = new_ent;
            end
        end else if (pop) begin
            ent0_next  = ent1_reg;
            q_cnt_next = q_cnt_reg - 1'b1;
        end else if (infl_reg) begin
            if (q_cnt_reg == 2'd0) begin
                ent0_next = new_ent;
            end else begin
                ent1_next = new_ent;
            end
            q_cnt_next = q_cnt_reg + 1'b1;
        end
    end

    assign m_out_i          = ent0_reg.i;
    assign m_out_q          = ent0_reg.q;
    assign m_returned_count = ent0_reg.count;
    assign m_empty_res      = ent0_reg.empty;
    assign m_last           = ent0_reg.last;

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            infl_reg  <= 1'b0;
            q_cnt_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            infl_reg  <= infl_next;
            q_cnt_reg <= q_cnt_next;
        end
        wanted_reg     <= wanted_next;
        dly_reg        <= dly_next;
        empty_reg      <= empty_next;
        back_reg       <= back_next;
        ptr_reg        <= ptr_next;
        rem_reg        <= rem_next;
        infl_last_reg  <= infl_last_next;
        infl_empty_reg <= infl_empty_next;
        infl_cnt_reg   <= infl_cnt_next;
        ent0_reg       <= ent0_next;
        ent1_reg       <= ent1_next;
    end

    // Frame store with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr_x[AW-1:0]] <= {s_sample_q, s_sample_i};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr_x[AW-1:0]];
        end
    end

    // The queue entries plus any read in flight never exceed two.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_cnt_reg + {1'b0, infl_reg}) <= 2'd2)
        else $error("output queue overrun");

    // History never exceeds the ring size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= cfg.capacity)
        else $error("fill count above capacity");

    // The head stays inside the ring, or at zero when the ring is disabled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg < cfg.capacity) || (head_reg == '0))
        else $error("head outside ring");

    // A read is issued only when the queue has room for its data once it leaves the registered read port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        infl_next |=> (q_cnt_reg < 2'd2) || $past(pop))
        else $error("read issued without queue room");

endmodule

// ===== design/iq_time_shift_ring_buffer_unit.sv =====
// Top level of the I/Q time-shift ring buffer: register port, stream packing, core.
// Writes and clears are accepted at one item per cycle while no read holds the input.
// A read holds the input until its last result is issued (an empty read has one result):
// the clamp and address states trim the delay and find the window start, then one store
// read is issued per cycle, stretched while the two-entry result queue is full.
// Reset clears capacity, head, fill and the queue.
module iq_time_shift_ring_buffer_unit
    import iqts_pkg::*;
#(
    parameter int MAX_FRAMES  = MAX_FRAMES_DEF,
    parameter int MAX_READ    = MAX_READ_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: sample_i, sample_q, read_length, delay, zero fill.
    input  logic [((2*SAMPLE_BITS+LEN_W+DELAY_W+7)/8)*8-1:0] s_tdata,
    // Field: opcode.
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: out_i, out_q, returned_count, zero fill.
    output logic [((2*SAMPLE_BITS+LEN_W+7)/8)*8-1:0] m_tdata,
    // Field: empty_res.
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int SB       = SAMPLE_BITS;
    localparam int M_DATA_W = ((2*SB+LEN_W+7)/8)*8;
    localparam logic [APB_DATA_W-1:0] MAX_FRAMES_W = APB_DATA_W'(MAX_FRAMES);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic             cap_write;
    logic [CAP_W-1:0] cap_raw;
    iqts_cfg_t        cfg;
    logic [SB-1:0]    out_i;
    logic [SB-1:0]    out_q;
    logic [LEN_W-1:0] returned_count;

    // Capacity register, saturated to the store depth.
    assign pready    = 1'b1;
    assign cap_write = psel && penable && pwrite && pready
                    && (paddr[2] == REG_CAPACITY) && (paddr[1:0] == 2'b00);
    assign cap_raw   = pwdata[CAP_W-1:0];

    always_comb begin
        capacity_next = capacity_reg;
        if (cap_write) begin
            if (APB_DATA_W'(cap_raw) > MAX_FRAMES_W) begin
                capacity_next = CAP_W'(MAX_FRAMES);
            end else begin
                capacity_next = cap_raw;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    // Register read-back.
    assign prdata = ((paddr[2] == REG_CAPACITY) && (paddr[1:0] == 2'b00))
                  ? APB_DATA_W'(capacity_reg) : '0;

    // A capacity write also empties the history.
    assign cfg.capacity   = capacity_reg;
    assign cfg.hist_clear = cap_write;

    iqts_core #(
        .MAX_FRAMES  (MAX_FRAMES),
        .MAX_READ    (MAX_READ),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_opcode         (s_tuser),
        .s_sample_i       (s_tdata[SB-1:0]),
        .s_sample_q       (s_tdata[2*SB-1:SB]),
        .s_read_length    (s_tdata[2*SB+LEN_W-1:2*SB]),
        .s_delay          (s_tdata[2*SB+LEN_W+DELAY_W-1:2*SB+LEN_W]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_out_i          (out_i),
        .m_out_q          (out_q),
        .m_returned_count (returned_count),
        .m_empty_res      (m_tuser),
        .m_last           (m_tlast)
    );

    // Pack the result transfer.
    assign m_tdata = M_DATA_W'({returned_count, out_q, out_i});

endmodule

// ===== sim/iq_time_shift_ring_buffer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the I/Q time-shift ring buffer.

module iq_time_shift_ring_buffer_unit_tb;
    import iqts_pkg::*;

    localparam int SDATA_W = ((2*SAMPLE_BITS_DEF+LEN_W+DELAY_W+7)/8)*8;
    localparam int MDATA_W = ((2*SAMPLE_BITS_DEF+LEN_W+7)/8)*8;
    localparam int SFIELD_W = 2*SAMPLE_BITS_DEF + LEN_W + DELAY_W;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 8;

    // One returned frame as it appears on the result channel.
    typedef struct packed {
        logic [15:0]      out_i;
        logic [15:0]      out_q;
        logic [LEN_W-1:0] count;
        logic             empty;
        logic             last;
    } frame_res_t;

    // Ring predictor plus the queue of frames still owed by the block.
    class frame_window_board;
        int unsigned capacity;
        int unsigned head;
        int unsigned fill;
        logic [31:0] ring_mem [MAX_FRAMES_DEF];
        frame_res_t  owed_frames[$];
        int errors;
        int frames_checked;
        int items_seen;
        int reads_seen;

        function void set_capacity(logic [CAP_W-1:0] value);
            capacity = (value > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : value;
            head = 0;
            fill = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        // Update the ring for one accepted transfer and queue the frames it returns.
        function void accept_item(logic [OP_W-1:0] op, logic [15:0] si, logic [15:0] sq,
                                  logic [LEN_W-1:0] len, logic [DELAY_W-1:0] dly);
            int unsigned n, wanted, deepest, d, idx, k;
            frame_res_t r;
            items_seen++;
            case (op)
                OP_WRITE: begin
                    if (capacity != 0 && head < capacity) begin
                        ring_mem[head] = {sq, si};
                        head++;
                        if (head >= capacity)
                            head = 0;
                        if (fill < capacity)
                            fill++;
                    end
                end
                OP_CLEAR: begin
                    head = 0;
                    fill = 0;
                end
                OP_READ: begin
                    reads_seen++;
                    n = (len > MAX_READ_DEF) ? MAX_READ_DEF : len;
                    wanted = (n < fill) ? n : fill;
                    if (capacity == 0 || wanted == 0) begin
                        r = '{16'd0, 16'd0, '0, 1'b1, 1'b1};
                        owed_frames.push_back(r);
                    end else begin
                        deepest = fill - wanted;
                        d = (dly > deepest) ? deepest : dly;
                        // Window start, wrapped back into the active part of the ring.
                        idx = head + capacity - (wanted + d);
                        if (idx >= capacity)
                            idx -= capacity;
                        for (k = 0; k < wanted; k++) begin
                            r.out_i = ring_mem[idx][15:0];
                            r.out_q = ring_mem[idx][31:16];
                            r.count = wanted[LEN_W-1:0];
                            r.empty = 1'b0;
                            r.last  = (k + 1 == wanted);
                            owed_frames.push_back(r);
                            idx++;
                            if (idx >= capacity)
                                idx = 0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // Compare one result transfer with the oldest owed frame.
        task check_frame(frame_res_t got);
            frame_res_t want;
            if (owed_frames.size() == 0) begin
                report_mismatch($sformatf("result transfer with nothing expected (i=%h q=%h)",
                                          got.out_i, got.out_q));
            end else begin
                want = owed_frames.pop_front();
                frames_checked++;
                if (got.out_i !== want.out_i)
                    report_mismatch($sformatf("out_i %h, expected %h", got.out_i, want.out_i));
                if (got.out_q !== want.out_q)
                    report_mismatch($sformatf("out_q %h, expected %h", got.out_q, want.out_q));
                if (got.count !== want.count)
                    report_mismatch($sformatf("returned_count %0d, expected %0d",
                                              got.count, want.count));
                if (got.empty !== want.empty)
                    report_mismatch($sformatf("empty_res %b, expected %b", got.empty, want.empty));
                if (got.last !== want.last)
                    report_mismatch($sformatf("tlast %b, expected %b", got.last, want.last));
            end
        endtask
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SDATA_W-1:0]    s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = OP_WRITE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [MDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    frame_window_board sb;
    int unsigned tx_gap_pct = 10;
    int unsigned rx_idle_pct = 18;
    int          rx_hold = 0;
    int          cycle_count = 0;
    int          config_writes = 0;

    iq_time_shift_ring_buffer_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped: cycle limit reached with %0d frames owed",
                     sb.owed_frames.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result receiver: random back-pressure, or a counted hold-off when requested.
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every result transfer.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_frame('{m_tdata[15:0], m_tdata[31:16], m_tdata[32 +: LEN_W],
                             m_tuser, m_tlast});
    end

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(19))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one input transfer, with an occasional gap before it.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [15:0] si,
                             input logic [15:0] sq, input logic [LEN_W-1:0] len,
                             input logic [DELAY_W-1:0] dly);
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(SDATA_W-SFIELD_W){1'b0}}, dly, len, sq, si};
        do @(posedge aclk); while (!s_tready);
        sb.accept_item(op, si, sq, len, dly);
    endtask

    // Random transfer shaped by the current fill so reads mostly hit real history.
    task automatic random_item();
        int unsigned pick, f, top;
        logic [LEN_W-1:0]   len;
        logic [DELAY_W-1:0] dly;
        pick = $urandom_range(99);
        f = sb.fill;
        top = (f + 2 > 127) ? 127 : f + 2;
        if (pick < 50) begin
            send_item(OP_WRITE, rand_sample(), rand_sample(), LEN_W'($urandom),
                      DELAY_W'($urandom));
        end else if (pick < 90) begin
            len = ($urandom_range(9) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(top));
            dly = ($urandom_range(4) == 0) ? DELAY_W'($urandom)
                                           : DELAY_W'($urandom_range(f > 4095 ? 4095 : f));
            send_item(OP_READ, 16'($urandom), 16'($urandom), len, dly);
        end else if (pick < 95) begin
            send_item(OP_CLEAR, 16'($urandom), 16'($urandom), LEN_W'($urandom),
                      DELAY_W'($urandom));
        end else begin
            send_item(OP_UNUSED, 16'($urandom), 16'($urandom), LEN_W'($urandom),
                      DELAY_W'($urandom));
        end
    endtask

    // Stop sending, wait for every owed frame, then let the pipeline settle.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.owed_frames.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup phase, then access phase until pready; then read it back.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {{(APB_DATA_W-CAP_W){1'b0}}, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_capacity(value);
        config_writes++;
        // Read transfer of the same register.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DATA_W'(sb.capacity))
            sb.report_mismatch($sformatf("capacity read %0d, expected %0d",
                                         prdata, sb.capacity));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] cap_list [6];
        cap_list = '{13'd1, 13'd5, 13'd17, 13'd64, 13'd8191, 13'd3};
        sb = new();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Capacity is zero after reset: writes are dropped and reads come back empty.
        send_item(OP_WRITE, 16'h1234, 16'h5678, '0, '0);
        send_item(OP_READ, '0, '0, 7'd5, '0);
        send_item(OP_UNUSED, '1, '1, '1, '1);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_READ, '0, '0, '0, '0);
        drain_block();

        // Small ring: sample extremes, oversize length and delay, wrap, clear.
        write_capacity(13'd4);
        send_item(OP_WRITE, 16'h7FFF, 16'h8000, '0, '0);
        send_item(OP_WRITE, 16'h8000, 16'h7FFF, '0, '0);
        send_item(OP_WRITE, 16'h0000, 16'hFFFF, '0, '0);
        send_item(OP_WRITE, 16'hFFFF, 16'h0000, '0, '0);
        send_item(OP_READ, '0, '0, 7'd127, 12'd4095);
        send_item(OP_WRITE, 16'h1111, 16'h2222, '0, '0);
        send_item(OP_WRITE, 16'h3333, 16'h4444, '0, '0);
        send_item(OP_READ, '0, '0, 7'd2, 12'd1);
        send_item(OP_READ, '0, '0, 7'd0, 12'd0);
        send_item(OP_READ, '0, '0, 7'd4, 12'd0);
        send_item(OP_CLEAR, '0, '0, '0, '0);
        send_item(OP_READ, '0, '0, 7'd3, 12'd0);
        send_item(OP_WRITE, 16'h5555, 16'h6666, '0, '0);
        send_item(OP_READ, '0, '0, 7'd1, 12'd4095);
        send_item(OP_UNUSED, 16'hA5A5, 16'h5A5A, 7'd64, 12'd7);
        send_item(OP_READ, '0, '0, 7'd64, 12'd0);

        // Random traffic over a range of ring sizes, the saturating one included.
        foreach (cap_list[c]) begin
            drain_block();
            write_capacity(cap_list[c]);
            repeat (20) random_item();
        end

        // Back-pressure: results are held off while reads keep arriving.
        drain_block();
        write_capacity(13'd32);
        repeat (40) send_item(OP_WRITE, rand_sample(), rand_sample(), '0, '0);
        rx_hold = 400;
        repeat (5) send_item(OP_READ, '0, '0, 7'd16, DELAY_W'($urandom_range(20)));
        send_item(OP_READ, '0, '0, 7'd64, 12'd0);
        drain_block();

        // Full-size ring with no idling on either side: deep delays are clamped.
        write_capacity(13'd4096);
        tx_gap_pct  = 0;
        rx_idle_pct = 0;
        repeat (50) send_item(OP_WRITE, rand_sample(), rand_sample(), '0, '0);
        send_item(OP_READ, '0, '0, 7'd64, 12'd4095);
        send_item(OP_READ, '0, '0, 7'd1, 12'd4095);
        send_item(OP_READ, '0, '0, 7'd127, 12'd0);
        send_item(OP_READ, '0, '0, 7'd10, 12'd2000);
        tx_gap_pct  = 10;
        rx_idle_pct = 18;
        drain_block();

        // Disabled again: everything must be dropped or empty.
        write_capacity(13'd0);
        repeat (15) random_item();
        drain_block();

        $display("Covered %0d input transfers (%0d reads) across %0d capacity settings.",
                 sb.items_seen, sb.reads_seen, config_writes);
        $display("Checked %0d result transfers, %0d mismatches.", sb.frames_checked, sb.errors);
        if (sb.errors == 0 && sb.owed_frames.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/iqts_pkg.sv
design/iqts_core.sv
design/iq_time_shift_ring_buffer_unit.sv
sim/iq_time_shift_ring_buffer_unit_tb.sv
